[src/whp_pkg.sv]
package whp_pkg;

  // RIFF tags, first byte of the stream most significant
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // fmt chunk codes
  localparam logic [15:0] FMT_TAG_PCM   = 16'd1;
  localparam logic [15:0] FMT_TAG_FLOAT = 16'd3;
  localparam logic [15:0] DEPTH_PCM     = 16'd16;
  localparam logic [15:0] DEPTH_FLOAT   = 16'd32;
  localparam logic [31:0] FMT_BODY_LEN  = 32'd16;

  // result kinds and error codes
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_RIFF  = 2'd1;
  localparam logic [1:0] ERR_WAVE  = 2'd2;
  localparam logic [1:0] ERR_UNSUP = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RIFF,
    PH_RSIZE,
    PH_WAVE,
    PH_CHDR,
    PH_FMT,
    PH_SKIP,
    PH_PAD,
    PH_DIV,
    PH_DATA,
    PH_DONE
  } whp_phase_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAG,
    OP_LEN,
    OP_FMT,
    OP_SKIP,
    OP_DIV_START,
    OP_SAMPLE,
    OP_ACCEPT,
    OP_REJECT
  } whp_op_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } whp_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] sample_word;
    logic [15:0] channel_index;
    logic        frame_last;
    logic        format_code;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] total_frames;
    logic [1:0]  error_code;
  } whp_out_t;

  // controller to datapath
  typedef struct packed {
    logic       clear;
    whp_op_e    op;
    logic [3:0] idx;
    logic       smp_end;
    logic [1:0] err;
  } whp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic nx_riff;
    logic nx_wave;
    logic cur_fmt;
    logic cur_data;
    logic len_zero;
    logic len_odd;
    logic fmt_extra;
    logic skip_last;
    logic supported;
    logic div_busy;
    logic frames_zero;
    logic is_float;
    logic last_chan;
    logic last_frame;
    logic out_free;
  } whp_sts_t;

endpackage

[src/wav_header_parser_sample_unpacker_top.sv]
// Channel  | Direction | Handshake               | Payload
// in       | input     | in_valid_i / in_ready_o   | in_data_i  (whp_in_t)
// out      | output    | out_valid_o / out_ready_i | out_data_o (whp_out_t)
//
// One byte is taken per cycle while the output register is free.
// At a supported data chunk header the frame count is found by a restoring
// divider, one quotient bit per cycle: input stalls there until the header result is emitted.
// rst_ni clears the controller phase, the divider and the output valid flag.
// A result waiting on out_ready_i holds the input side until it is taken.
module wav_header_parser_sample_unpacker_top
  import whp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  whp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output whp_out_t out_data_o
);

  whp_cmd_t cmd;
  whp_sts_t sts;

  whp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .file_start_i (in_data_i.file_start),
    .in_ready_o   (in_ready_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  whp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (in_data_i.data_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/whp_ctrl.sv]
module whp_ctrl
  import whp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     file_start_i,
  output logic     in_ready_o,
  input  whp_sts_t sts_i,
  output whp_cmd_t cmd_o
);

  whp_phase_e phase_q, phase_d;
  logic [3:0] cnt_q, cnt_d;
  logic       pad_q, pad_d;

  whp_phase_e ph;
  logic [3:0] k;
  logic       acc;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      pad_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      pad_q   <= pad_d;
    end
  end

  // hold input while dividing or while a result waits
  assign in_ready_o = (phase_q != PH_DIV) && sts_i.out_free;
  assign acc        = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    pad_d   = pad_q;
    cmd_o   = '{clear: 1'b0, op: OP_NONE, idx: '0, smp_end: 1'b0, err: ERR_NONE};
    ph      = file_start_i ? PH_RIFF : phase_q;
    k       = file_start_i ? 4'd0 : cnt_q;

    if (acc) begin
      cmd_o.clear = file_start_i;
      cmd_o.idx   = k;
      if (file_start_i) begin
        pad_d = 1'b0;
      end
      case (ph)
        PH_RIFF, PH_WAVE: begin
          cmd_o.op = OP_TAG;
          if (k == 4'd3) begin
            cnt_d = '0;
            if (ph == PH_RIFF) begin
              if (sts_i.nx_riff) begin
                phase_d = PH_RSIZE;
              end else begin
                cmd_o.op  = OP_REJECT;
                cmd_o.err = ERR_RIFF;
                phase_d   = PH_DONE;
              end
            end else begin
              if (sts_i.nx_wave) begin
                phase_d = PH_CHDR;
              end else begin
                cmd_o.op  = OP_REJECT;
                cmd_o.err = ERR_WAVE;
                phase_d   = PH_DONE;
              end
            end
          end else begin
            cnt_d   = k + 4'd1;
            phase_d = ph;
          end
        end
        PH_RSIZE: begin
          if (k == 4'd3) begin
            cnt_d   = '0;
            phase_d = PH_WAVE;
          end else begin
            cnt_d = k + 4'd1;
          end
        end
        PH_CHDR: begin
          cmd_o.op = (k < 4'd4) ? OP_TAG : OP_LEN;
          cnt_d    = k + 4'd1;
          if (k == 4'd7) begin
            cnt_d = '0;
            if (sts_i.cur_fmt) begin
              phase_d = PH_FMT;
            end else if (sts_i.cur_data) begin
              if (sts_i.supported && !sts_i.len_zero) begin
                cmd_o.op = OP_DIV_START;
                phase_d  = PH_DIV;
              end else begin
                cmd_o.op  = OP_REJECT;
                cmd_o.err = ERR_UNSUP;
                phase_d   = PH_DONE;
              end
            end else begin
              pad_d   = sts_i.len_odd;
              phase_d = sts_i.len_zero ? PH_CHDR : PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          cmd_o.op = OP_FMT;
          cnt_d    = k + 4'd1;
          if (k == 4'd15) begin
            cnt_d   = '0;
            pad_d   = 1'b0;
            phase_d = sts_i.fmt_extra ? PH_SKIP : PH_CHDR;
          end
        end
        PH_SKIP: begin
          cmd_o.op = OP_SKIP;
          if (sts_i.skip_last) begin
            phase_d = pad_q ? PH_PAD : PH_CHDR;
          end
        end
        PH_PAD: begin
          pad_d   = 1'b0;
          phase_d = PH_CHDR;
        end
        PH_DATA: begin
          cmd_o.op      = OP_SAMPLE;
          cmd_o.smp_end = (k == (sts_i.is_float ? 4'd3 : 4'd1));
          if (cmd_o.smp_end) begin
            cnt_d = '0;
            if (sts_i.last_chan && sts_i.last_frame) begin
              phase_d = PH_DONE;
            end
          end else begin
            cnt_d = k + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end else if (phase_q == PH_DIV) begin
      // emit the header result once the quotient is ready
      if (!sts_i.div_busy && sts_i.out_free) begin
        cmd_o.op = OP_ACCEPT;
        cnt_d    = '0;
        phase_d  = sts_i.frames_zero ? PH_DONE : PH_DATA;
      end
    end
  end

endmodule

[src/whp_dpath.sv]
module whp_dpath
  import whp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  whp_cmd_t   cmd_i,
  output whp_sts_t   sts_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output whp_out_t   out_data_o
);

  logic [31:0] tag_q;
  logic [31:0] len_q;
  logic [15:0] fmt_tag_q;
  logic [15:0] chans_q;
  logic [31:0] rate_q;
  logic [15:0] depth_q;
  logic        fmt_seen_q;
  logic [31:0] smp_q;
  logic [15:0] ch_cnt_q;
  logic [31:0] frames_done_q;

  // divider: quo_q holds the frame count once done
  logic [31:0] quo_q;
  logic [15:0] rem_q;
  logic [4:0]  dcnt_q;
  logic        busy_q;

  logic        out_valid_q;
  whp_out_t    out_q;

  logic [31:0] tag_nx;
  logic [31:0] len_full;
  logic [31:0] dividend;
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [16:0] rem_diff;
  logic        is_float;
  logic [31:0] smp_word;
  logic        emit;
  whp_out_t    res;

  assign tag_nx   = {tag_q[23:0], data_byte_i};
  assign len_full = {data_byte_i, len_q[23:0]};
  assign is_float = (fmt_tag_q == FMT_TAG_FLOAT);
  assign dividend = is_float ? {2'b00, len_full[31:2]} : {1'b0, len_full[31:1]};
  assign rem_sh   = {rem_q, quo_q[31]};
  assign rem_ge   = (rem_sh >= {1'b0, chans_q});
  assign rem_diff = rem_sh - {1'b0, chans_q};
  assign smp_word = is_float ? {data_byte_i, smp_q[23:0]} :
                               {16'h0000, data_byte_i, smp_q[7:0]};

  // status toward the controller
  always_comb begin
    sts_o.nx_riff     = (tag_nx == TAG_RIFF);
    sts_o.nx_wave     = (tag_nx == TAG_WAVE);
    sts_o.cur_fmt     = (tag_q == TAG_FMT);
    sts_o.cur_data    = (tag_q == TAG_DATA);
    sts_o.len_zero    = (len_full == 32'd0);
    sts_o.len_odd     = len_full[0];
    sts_o.fmt_extra   = (len_q > FMT_BODY_LEN);
    sts_o.skip_last   = (len_q == 32'd1);
    sts_o.supported   = fmt_seen_q && (chans_q != 16'd0) &&
                        (((fmt_tag_q == FMT_TAG_PCM) && (depth_q == DEPTH_PCM)) ||
                         ((fmt_tag_q == FMT_TAG_FLOAT) && (depth_q == DEPTH_FLOAT)));
    sts_o.div_busy    = busy_q;
    sts_o.frames_zero = (quo_q == 32'd0);
    sts_o.is_float    = is_float;
    sts_o.last_chan   = (ch_cnt_q + 16'd1 == chans_q);
    sts_o.last_frame  = (frames_done_q + 32'd1 == quo_q);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  // header fields and byte assembly
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_TAG: tag_q <= tag_nx;
      OP_LEN: len_q[8*cmd_i.idx[1:0] +: 8] <= data_byte_i;
      OP_FMT: begin
        case (cmd_i.idx) inside
          4'd0:        fmt_tag_q[7:0]  <= data_byte_i;
          4'd1:        fmt_tag_q[15:8] <= data_byte_i;
          4'd2:        chans_q[7:0]    <= data_byte_i;
          4'd3:        chans_q[15:8]   <= data_byte_i;
          [4'd4:4'd7]: rate_q[8*cmd_i.idx[1:0] +: 8] <= data_byte_i;
          4'd14:       depth_q[7:0]    <= data_byte_i;
          4'd15: begin
            depth_q[15:8] <= data_byte_i;
            len_q         <= len_q - FMT_BODY_LEN;
          end
          default: begin
          end
        endcase
      end
      OP_SKIP: len_q <= len_q - 32'd1;
      OP_SAMPLE: begin
        if (cmd_i.idx[1:0] == 2'd0) begin
          smp_q <= {24'h000000, data_byte_i};
        end else begin
          smp_q[8*cmd_i.idx[1:0] +: 8] <= data_byte_i;
        end
        if (cmd_i.smp_end) begin
          if (sts_o.last_chan) begin
            ch_cnt_q      <= '0;
            frames_done_q <= frames_done_q + 32'd1;
          end else begin
            ch_cnt_q <= ch_cnt_q + 16'd1;
          end
        end
      end
      OP_ACCEPT: begin
        ch_cnt_q      <= '0;
        frames_done_q <= '0;
      end
      default: begin
      end
    endcase
  end

  // fmt chunk seen flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_seen_q <= 1'b0;
    end else if (cmd_i.clear) begin
      fmt_seen_q <= 1'b0;
    end else if (cmd_i.op == OP_FMT && cmd_i.idx == 4'd15) begin
      fmt_seen_q <= 1'b1;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      dcnt_q <= '0;
    end else if (cmd_i.op == OP_DIV_START) begin
      busy_q <= 1'b1;
      dcnt_q <= '0;
    end else if (busy_q) begin
      dcnt_q <= dcnt_q + 5'd1;
      if (dcnt_q == 5'd31) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DIV_START) begin
      quo_q <= dividend;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[30:0], rem_ge};
      rem_q <= rem_ge ? rem_diff[15:0] : rem_sh[15:0];
    end
  end

  // build the result transaction
  always_comb begin
    res  = '0;
    emit = 1'b0;
    case (cmd_i.op)
      OP_SAMPLE: begin
        emit              = cmd_i.smp_end;
        res.result_kind   = KIND_SAMPLE;
        res.sample_word   = smp_word;
        res.channel_index = ch_cnt_q;
        res.frame_last    = sts_o.last_chan;
        res.format_code   = is_float;
      end
      OP_ACCEPT: begin
        emit              = 1'b1;
        res.result_kind   = KIND_ACCEPT;
        res.format_code   = is_float;
        res.channel_count = chans_q;
        res.sample_rate   = rate_q;
        res.total_frames  = quo_q;
      end
      OP_REJECT: begin
        emit            = 1'b1;
        res.result_kind = KIND_REJECT;
        res.error_code  = cmd_i.err;
      end
      default: begin
      end
    endcase
  end

  // output register: load on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/whp_checker.sv]
module whp_checker
  import whp_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input whp_out_t out_data_o
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // input is taken only when the pending result leaves
  a_in_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("input taken over a stalled result");

  // accepted header always carries a nonzero channel count
  a_accept_chans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_ACCEPT |->
      out_data_o.channel_count != 16'd0 && out_data_o.error_code == ERR_NONE)
    else $error("accept without channels");

  // reject carries an error code and no header fields
  a_reject_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_REJECT |->
      out_data_o.error_code != ERR_NONE && out_data_o.total_frames == 32'd0)
    else $error("reject without error code");

  // PCM samples keep the upper half clear
  a_pcm_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_SAMPLE && !out_data_o.format_code |->
      out_data_o.sample_word[31:16] == 16'h0000)
    else $error("PCM sample with upper bits set");

endmodule

bind wav_header_parser_sample_unpacker_top whp_checker u_whp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import whp_pkg::*;

  localparam int          QUIET_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          IDLE_PCT     = 36;
  localparam int          STREAM_ITEMS = 25 + 1350;
  localparam logic [31:0] TAG_LIST     = 32'h4C49_5354;

  // parser state as seen by the predictor
  typedef enum logic [3:0] {
    S_WAIT,
    S_RIFF_TAG,
    S_RIFF_LEN,
    S_WAVE_TAG,
    S_CHUNK_HDR,
    S_FMT_BODY,
    S_SKIP_BODY,
    S_SKIP_PAD,
    S_SAMPLES,
    S_FINISHED
  } parse_state_e;

  // one streamed byte, with a hand-written result where one is fixed
  typedef struct packed {
    whp_in_t  item;
    logic     fixed_want;
    whp_out_t fixed_result;
  } byte_rec_t;

  typedef struct packed {
    logic [7:0] b;
    logic       start;
    logic [1:0] err;
  } dir_row_t;

  // shape of one generated file
  typedef struct packed {
    logic [31:0] riff_tag;
    logic [31:0] wave_tag;
    logic [31:0] junk_before;
    logic [31:0] junk_after;
    logic        early_fmt;
    logic        with_fmt;
    logic [15:0] fmt_tag;
    logic [15:0] chans;
    logic [15:0] depth;
    logic [31:0] rate;
    logic [31:0] fmt_len;
    logic        with_data;
    logic [31:0] data_len;
    logic [31:0] body_bytes;
    logic [31:0] tail_bytes;
  } wav_plan_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  whp_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  whp_out_t out_data;

  byte_rec_t   stream_q[$];
  whp_out_t    pending_results[$];
  byte_rec_t   cur_rec;
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  int unsigned bytes_taken    = 0;
  bit          steady;

  // predictor state
  parse_state_e st;
  logic [31:0]  tag_sr;
  logic [31:0]  byte_pos;
  logic [31:0]  chunk_len;
  logic [15:0]  fmt_tag_q;
  logic [15:0]  chans_q;
  logic [31:0]  rate_q;
  logic [15:0]  depth_q;
  logic         fmt_seen_q;
  logic [31:0]  frames_tot;
  logic [31:0]  frames_cnt;
  logic [15:0]  chan_cnt;
  logic [31:0]  sample_sr;
  logic [1:0]   sample_pos;

  // tag errors, ignored bytes and a restart inside a tag
  dir_row_t directed_rows [25] = '{
    '{8'h00, 1'b0, ERR_NONE},
    '{8'hFF, 1'b0, ERR_NONE},
    '{"R",   1'b1, ERR_NONE},
    '{"I",   1'b0, ERR_NONE},
    '{"F",   1'b0, ERR_NONE},
    '{"X",   1'b0, ERR_RIFF},
    '{8'hA5, 1'b0, ERR_NONE},
    '{"R",   1'b1, ERR_NONE},
    '{"I",   1'b0, ERR_NONE},
    '{"F",   1'b0, ERR_NONE},
    '{"F",   1'b0, ERR_NONE},
    '{8'hFF, 1'b0, ERR_NONE},
    '{8'hFF, 1'b0, ERR_NONE},
    '{8'hFF, 1'b0, ERR_NONE},
    '{8'hFF, 1'b0, ERR_NONE},
    '{"W",   1'b0, ERR_NONE},
    '{"A",   1'b0, ERR_NONE},
    '{"V",   1'b0, ERR_NONE},
    '{"F",   1'b0, ERR_WAVE},
    '{"R",   1'b1, ERR_NONE},
    '{"I",   1'b0, ERR_NONE},
    '{"R",   1'b1, ERR_NONE},
    '{"I",   1'b0, ERR_NONE},
    '{"F",   1'b0, ERR_NONE},
    '{"F",   1'b0, ERR_NONE}
  };

  wav_header_parser_sample_unpacker_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_parser();
    st         = S_WAIT;
    tag_sr     = '0;
    byte_pos   = '0;
    chunk_len  = '0;
    fmt_tag_q  = '0;
    chans_q    = '0;
    rate_q     = '0;
    depth_q    = '0;
    fmt_seen_q = 1'b0;
    frames_tot = '0;
    frames_cnt = '0;
    chan_cnt   = '0;
    sample_sr  = '0;
    sample_pos = '0;
  endfunction

  // skip a chunk body, then an optional pad byte
  function automatic void start_skip(logic [31:0] len, logic pad);
    byte_pos = {31'b0, pad};
    if (len != 0) begin
      chunk_len = len;
      st = S_SKIP_BODY;
    end else if (pad) begin
      st = S_SKIP_PAD;
    end else begin
      byte_pos = '0;
      st = S_CHUNK_HDR;
    end
  endfunction

  function automatic whp_out_t reject_header(logic [1:0] code);
    whp_out_t r;
    r = '0;
    r.result_kind = KIND_REJECT;
    r.error_code = code;
    st = S_FINISHED;
    return r;
  endfunction

  // decide on the data chunk header and size the sample run
  function automatic whp_out_t close_header();
    whp_out_t    r;
    logic [31:0] frame_bytes;
    logic        ok;
    r = '0;
    ok = fmt_seen_q && chans_q != 0 &&
         ((fmt_tag_q == FMT_TAG_PCM && depth_q == DEPTH_PCM) ||
          (fmt_tag_q == FMT_TAG_FLOAT && depth_q == DEPTH_FLOAT));
    if (!ok || chunk_len == 0) return reject_header(ERR_UNSUP);
    frame_bytes = 32'(chans_q) * 32'(depth_q >> 3);
    frames_tot = chunk_len / frame_bytes;
    frames_cnt = '0;
    chan_cnt = '0;
    sample_sr = '0;
    sample_pos = '0;
    r.result_kind = KIND_ACCEPT;
    r.format_code = (fmt_tag_q == FMT_TAG_FLOAT);
    r.channel_count = chans_q;
    r.sample_rate = rate_q;
    r.total_frames = frames_tot;
    st = (frames_tot == 0) ? S_FINISHED : S_SAMPLES;
    return r;
  endfunction

  // advance the parser by one byte; return 1 when a result comes out
  function automatic bit parse_byte(input whp_in_t it, output whp_out_t r);
    logic [7:0]  b;
    int unsigned k;
    int unsigned width;
    b = it.data_byte;
    r = '0;
    if (it.file_start) begin
      clear_parser();
      st = S_RIFF_TAG;
    end
    case (st)
      S_RIFF_TAG, S_WAVE_TAG: begin
        tag_sr = {tag_sr[23:0], b};
        byte_pos++;
        if (byte_pos < 4) return 1'b0;
        byte_pos = '0;
        if (st == S_RIFF_TAG) begin
          if (tag_sr != TAG_RIFF) begin
            r = reject_header(ERR_RIFF);
            return 1'b1;
          end
          st = S_RIFF_LEN;
        end else begin
          if (tag_sr != TAG_WAVE) begin
            r = reject_header(ERR_WAVE);
            return 1'b1;
          end
          st = S_CHUNK_HDR;
        end
        return 1'b0;
      end
      S_RIFF_LEN: begin
        byte_pos++;
        if (byte_pos >= 4) begin
          byte_pos = '0;
          st = S_WAVE_TAG;
        end
        return 1'b0;
      end
      S_CHUNK_HDR: begin
        k = byte_pos & 7;
        if (k < 4) begin
          tag_sr = {tag_sr[23:0], b};
        end else begin
          if (k == 4) chunk_len = '0;
          chunk_len |= 32'(b) << (8 * (k - 4));
        end
        byte_pos = k + 1;
        if (k != 7) return 1'b0;
        byte_pos = '0;
        if (tag_sr == TAG_FMT) begin
          st = S_FMT_BODY;
          return 1'b0;
        end
        if (tag_sr == TAG_DATA) begin
          r = close_header();
          return 1'b1;
        end
        start_skip(chunk_len, chunk_len[0]);
        return 1'b0;
      end
      S_FMT_BODY: begin
        k = byte_pos & 15;
        if (k < 2) begin
          fmt_tag_q = (k == 0) ? 16'(b) : (fmt_tag_q | {b, 8'h00});
        end else if (k < 4) begin
          chans_q = (k == 2) ? 16'(b) : (chans_q | {b, 8'h00});
        end else if (k < 8) begin
          if (k == 4) rate_q = '0;
          rate_q |= 32'(b) << (8 * (k - 4));
        end else if (k >= 14) begin
          depth_q = (k == 14) ? 16'(b) : (depth_q | {b, 8'h00});
        end
        byte_pos = k + 1;
        if (k != 15) return 1'b0;
        fmt_seen_q = 1'b1;
        start_skip((chunk_len > FMT_BODY_LEN) ? chunk_len - FMT_BODY_LEN : 32'd0, 1'b0);
        return 1'b0;
      end
      S_SKIP_BODY: begin
        chunk_len--;
        if (chunk_len == 0) st = (byte_pos != 0) ? S_SKIP_PAD : S_CHUNK_HDR;
        return 1'b0;
      end
      S_SKIP_PAD: begin
        byte_pos = '0;
        st = S_CHUNK_HDR;
        return 1'b0;
      end
      S_SAMPLES: begin
        k = 32'(sample_pos);
        if (k == 0) sample_sr = '0;
        sample_sr |= 32'(b) << (8 * k);
        width = (fmt_tag_q == FMT_TAG_FLOAT) ? 4 : 2;
        if (k + 1 < width) begin
          sample_pos = 2'(k + 1);
          return 1'b0;
        end
        sample_pos = '0;
        r.result_kind = KIND_SAMPLE;
        r.sample_word = sample_sr;
        r.channel_index = chan_cnt;
        r.format_code = (fmt_tag_q == FMT_TAG_FLOAT);
        if (32'(chan_cnt) + 1 >= 32'(chans_q)) begin
          r.frame_last = 1'b1;
          chan_cnt = '0;
          frames_cnt++;
          if (frames_cnt >= frames_tot) st = S_FINISHED;
        end else begin
          chan_cnt++;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void put(logic [7:0] b, logic start = 1'b0,
                              logic [1:0] reject_err = ERR_NONE);
    byte_rec_t r;
    r = '0;
    r.item.data_byte = b;
    r.item.file_start = start;
    if (reject_err != ERR_NONE) begin
      r.fixed_want = 1'b1;
      r.fixed_result.result_kind = KIND_REJECT;
      r.fixed_result.error_code = reject_err;
    end
    stream_q.push_back(r);
  endfunction

  function automatic void put_tag(logic [31:0] t, logic start = 1'b0);
    put(t[31:24], start);
    put(t[23:16]);
    put(t[15:8]);
    put(t[7:0]);
  endfunction

  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) put(v[8*i +: 8]);
  endfunction

  // a foreign chunk; a huge size is cut short and ends the file
  function automatic bit put_junk();
    logic [31:0] size;
    size = ($urandom_range(19) == 0) ? 32'hFFFF_FFFF - $urandom_range(1) : $urandom_range(9);
    put_tag(($urandom_range(1) == 0) ? TAG_LIST : $urandom);
    put_le(size, 4);
    if (size > 64) begin
      repeat (12) put(8'($urandom));
      return 1'b0;
    end
    repeat (size + 32'(size[0])) put(8'($urandom));
    return 1'b1;
  endfunction

  function automatic bit put_fmt(logic [15:0] tag, logic [15:0] chans, logic [31:0] rate,
                                 logic [15:0] depth, logic [31:0] len);
    logic [31:0] extra;
    put_tag(TAG_FMT);
    put_le(len, 4);
    put_le(32'(tag), 2);
    put_le(32'(chans), 2);
    put_le(rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le(32'(depth), 2);
    extra = (len > FMT_BODY_LEN) ? len - FMT_BODY_LEN : 32'd0;
    if (extra > 24) begin
      repeat (12) put(8'($urandom));
      return 1'b0;
    end
    repeat (extra) put(8'($urandom));
    return 1'b1;
  endfunction

  function automatic wav_plan_t make_plan(int unsigned n);
    wav_plan_t   p;
    int unsigned roll;
    int unsigned frame_bytes;
    int unsigned frames;
    bit          use_float;
    p = '0;
    p.riff_tag = TAG_RIFF;
    p.wave_tag = TAG_WAVE;
    roll = $urandom_range(99);
    if (roll < 4) p.riff_tag = TAG_RIFF ^ (32'd1 << $urandom_range(31));
    else if (roll < 8) p.wave_tag = TAG_WAVE ^ (32'd1 << $urandom_range(31));
    p.junk_before = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
    p.junk_after = ($urandom_range(5) == 0) ? 1 : 0;
    p.early_fmt = ($urandom_range(9) == 0);
    p.with_fmt = ($urandom_range(29) != 0);
    use_float = ($urandom_range(1) == 1);
    p.fmt_tag = use_float ? FMT_TAG_FLOAT : FMT_TAG_PCM;
    p.depth = use_float ? DEPTH_FLOAT : DEPTH_PCM;
    if ($urandom_range(19) == 0) p.fmt_tag = 16'($urandom_range(4));
    if ($urandom_range(19) == 0) p.depth = 16'($urandom_range(5) * 8);
    roll = $urandom_range(99);
    if (roll < 3) p.chans = '0;
    else if (roll < 6) p.chans = 16'hFFFF;
    else if (roll < 12) p.chans = 16'($urandom_range(40, 5));
    else p.chans = 16'($urandom_range(4, 1));
    case ($urandom_range(5))
      0: p.rate = 32'd8000;
      1: p.rate = 32'd44100;
      2: p.rate = 32'd48000;
      3: p.rate = 32'd0;
      4: p.rate = 32'hFFFF_FFFF;
      default: p.rate = $urandom;
    endcase
    roll = $urandom_range(99);
    if (roll < 10) p.fmt_len = $urandom_range(15);
    else if (roll < 20) p.fmt_len = $urandom_range(23, 17);
    else if (roll < 23) p.fmt_len = 32'hFFFF_FFFF;
    else p.fmt_len = FMT_BODY_LEN;
    p.with_data = ($urandom_range(24) != 0);

    // first files: a clean frame with one special case each
    if (n < 7) begin
      p.riff_tag = TAG_RIFF;
      p.wave_tag = TAG_WAVE;
      p.with_fmt = 1'b1;
      p.with_data = 1'b1;
      p.fmt_tag = use_float ? FMT_TAG_FLOAT : FMT_TAG_PCM;
      p.depth = use_float ? DEPTH_FLOAT : DEPTH_PCM;
      p.chans = 16'd2;
      p.fmt_len = FMT_BODY_LEN;
    end
    case (n)
      0: begin
        p.fmt_len = $urandom_range(15);
        p.junk_before = 1;
      end
      1: begin
        p.fmt_tag = FMT_TAG_FLOAT;
        p.depth = DEPTH_FLOAT;
        p.fmt_len = $urandom_range(23, 17);
        p.early_fmt = 1'b1;
      end
      4: p.chans = '0;
      5: p.with_data = 1'b0;
      6: p.junk_after = 1;
      default: ;
    endcase

    frame_bytes = 32'(p.chans) * 32'(p.depth >> 3);
    if (frame_bytes == 0) frame_bytes = 2;
    frames = $urandom_range(4, 1);
    roll = $urandom_range(99);
    if (roll < 4) p.data_len = '0;
    else if (roll < 8) p.data_len = 32'hFFFF_FFFF;
    else if (roll < 12) p.data_len = frame_bytes - 1;
    else p.data_len = frames * frame_bytes +
                      (($urandom_range(3) == 0) ? $urandom_range(frame_bytes - 1) : 0);
    if (n == 2) p.data_len = '0;
    if (n == 3) p.data_len = frame_bytes - 1;
    if (n < 2 || n > 3) begin
      if (n < 7) p.data_len = frames * frame_bytes;
    end
    p.body_bytes = (p.data_len <= 200) ? p.data_len : $urandom_range(48, 8);
    p.tail_bytes = $urandom_range(2);
    return p;
  endfunction

  function automatic void queue_wav(wav_plan_t p);
    put_tag(p.riff_tag, 1'b1);
    put_le($urandom, 4);
    put_tag(p.wave_tag);
    if (p.riff_tag != TAG_RIFF || p.wave_tag != TAG_WAVE) begin
      put(8'($urandom));
      return;
    end
    for (int i = 0; i < p.junk_before; i++) if (!put_junk()) return;
    if (p.early_fmt) void'(put_fmt(16'($urandom), 16'($urandom), $urandom, 16'($urandom),
                                   FMT_BODY_LEN));
    if (p.with_fmt && !put_fmt(p.fmt_tag, p.chans, p.rate, p.depth, p.fmt_len)) return;
    for (int i = 0; i < p.junk_after; i++) if (!put_junk()) return;
    if (!p.with_data) return;
    put_tag(TAG_DATA);
    put_le(p.data_len, 4);
    repeat (p.body_bytes) put(8'($urandom));
    repeat (p.tail_bytes) put(8'($urandom));
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("%0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic check_result(whp_out_t got, whp_out_t want);
    if (got.result_kind !== want.result_kind)
      report_mismatch("result_kind", 32'(got.result_kind), 32'(want.result_kind));
    if (got.sample_word !== want.sample_word)
      report_mismatch("sample_word", got.sample_word, want.sample_word);
    if (got.channel_index !== want.channel_index)
      report_mismatch("channel_index", 32'(got.channel_index), 32'(want.channel_index));
    if (got.frame_last !== want.frame_last)
      report_mismatch("frame_last", 32'(got.frame_last), 32'(want.frame_last));
    if (got.format_code !== want.format_code)
      report_mismatch("format_code", 32'(got.format_code), 32'(want.format_code));
    if (got.channel_count !== want.channel_count)
      report_mismatch("channel_count", 32'(got.channel_count), 32'(want.channel_count));
    if (got.sample_rate !== want.sample_rate)
      report_mismatch("sample_rate", got.sample_rate, want.sample_rate);
    if (got.total_frames !== want.total_frames)
      report_mismatch("total_frames", got.total_frames, want.total_frames);
    if (got.error_code !== want.error_code)
      report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
  endtask

  // predict on each input transaction, check each output transaction, drive the next
  always @(posedge clk) begin : bench_loop
    whp_out_t predicted;
    bit       produces;
    bit       moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        produces = parse_byte(cur_rec.item, predicted);
        if (cur_rec.fixed_want) pending_results.push_back(cur_rec.fixed_result);
        else if (produces) pending_results.push_back(predicted);
        bytes_taken++;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0)
          report_mismatch("result with nothing pending, kind", 32'(out_data.result_kind), 32'd0);
        else
          check_result(out_data, pending_results.pop_front());
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;

      // no idling on either side for a stretch in the middle
      steady = (bytes_taken >= 600 && bytes_taken < 800);
      if (!in_valid || in_ready) begin
        if (stream_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          cur_rec = stream_q.pop_front();
          in_valid <= 1'b1;
          in_data <= cur_rec.item;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // end the run when nothing moves for too long
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("wav_header_parser_sample_unpacker_top: mismatch");
    $finish;
  end

  initial begin : main_seq
    int unsigned n;
    clear_parser();
    foreach (directed_rows[i])
      put(directed_rows[i].b, directed_rows[i].start, directed_rows[i].err);
    n = 0;
    while (stream_q.size() < STREAM_ITEMS) begin
      // occasional loose bytes between files
      if (n >= 7 && $urandom_range(19) == 0)
        repeat ($urandom_range(12, 1)) put(8'($urandom), $urandom_range(7) == 0);
      queue_wav(make_plan(n));
      n++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // drain the stream, then every pending result
    while (stream_q.size() != 0 || in_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("wav_header_parser_sample_unpacker_top: match");
    end else begin
      $display("wav_header_parser_sample_unpacker_top: mismatch");
    end
    $finish;
  end

endmodule

[wav_header_parser_sample_unpacker_top.f]
src/whp_pkg.sv
src/whp_ctrl.sv
src/whp_dpath.sv
src/wav_header_parser_sample_unpacker_top.sv
src/whp_checker.sv
tb/sv/tb_top.sv
